// File: hw/rtl/next_lexicographic_arrangement_assert.svh
// Assertion macros for the next lexicographic arrangement block.
`ifndef NEXT_LEXICOGRAPHIC_ARRANGEMENT_ASSERT_SVH
`define NEXT_LEXICOGRAPHIC_ARRANGEMENT_ASSERT_SVH
`ifndef SYNTHESIS
`define NLA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nla: assertion failed");
`define NLA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("nla: assertion failed");
`else
`define NLA_ASSERT_IMPLY(lbl, ante, cons)
`define NLA_ASSERT_ALWAYS(lbl, expr)
`endif
`endif

// File: hw/rtl/nla_pkg.sv
// Shared constants, types and stage payloads for the arrangement pipeline.
package nla_pkg;

    localparam int MAX_LEN  = 8;
    localparam int SYM_BITS = 16;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int LEN_IN_W = 4;

    typedef logic [SYM_BITS-1:0] sym_t;
    typedef sym_t [MAX_LEN-1:0]  word_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [LEN_W-1:0]    len_t;

    // after ascent detection
    typedef struct packed {
        word_t              word;
        len_t               n;
        logic [MAX_LEN-2:0] asc;
    } s1_t;

    // after pivot selection
    typedef struct packed {
        word_t word;
        len_t  n;
        idx_t  p;
        logic  has_piv;
        sym_t  pv;
    } s2_t;

    // after successor search
    typedef struct packed {
        word_t word;
        len_t  n;
        idx_t  p;
        idx_t  j;
        logic  wrap;
    } s3_t;

endpackage

// File: hw/rtl/nla_detect.sv
// Stage 1: length saturation and ascent flags between neighbouring symbols.
module nla_detect
    import nla_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [LEN_IN_W-1:0] sym_count,
    input  word_t               word_in,
    output logic                out_valid,
    input  logic                out_ready,
    output s1_t                 out_data
);

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    always_comb
    begin
        data_next.word = word_in;
        if (sym_count > LEN_IN_W'(MAX_LEN))
            data_next.n = LEN_W'(MAX_LEN);
        else
            data_next.n = LEN_W'(sym_count);
        for (int k = 0; k < MAX_LEN - 1; k++)
        begin
            data_next.asc[k] = (LEN_W'(k + 1) < data_next.n) && (word_in[k] < word_in[k + 1]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/nla_pivot.sv
// Stage 2: rightmost ascent picks the pivot and its symbol.
module nla_pivot
    import nla_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_data
);

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    always_comb
    begin
        data_next.word    = in_data.word;
        data_next.n       = in_data.n;
        data_next.p       = '0;
        data_next.has_piv = 1'b0;
        // later hits overwrite, so the rightmost ascent wins
        for (int k = 0; k < MAX_LEN - 1; k++)
        begin
            if (in_data.asc[k])
            begin
                data_next.p       = IDX_W'(k);
                data_next.has_piv = 1'b1;
            end
        end
        data_next.pv = in_data.word[data_next.p];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/nla_succ.sv
// Stage 3: rightmost symbol after the pivot that is larger than it.
`include "next_lexicographic_arrangement_assert.svh"
module nla_succ
    import nla_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s2_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s3_t  out_data
);

    logic valid_reg;
    s3_t  data_reg;
    s3_t  data_next;

    always_comb
    begin
        data_next.word = in_data.word;
        data_next.n    = in_data.n;
        data_next.p    = in_data.p;
        data_next.wrap = !in_data.has_piv;
        data_next.j    = '0;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            if (in_data.has_piv && (IDX_W'(k) > in_data.p) && (LEN_W'(k) < in_data.n)
                && (in_data.word[k] > in_data.pv))
                data_next.j = IDX_W'(k);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // successor sits inside the valid part, right of the pivot
    `NLA_ASSERT_ALWAYS(a_succ_range, !valid_reg || data_reg.wrap || ((data_reg.j > data_reg.p) && (LEN_W'(data_reg.j) < data_reg.n)))
    `NLA_ASSERT_IMPLY(a_succ_larger, valid_reg && !data_reg.wrap, data_reg.word[data_reg.j] > data_reg.word[data_reg.p])

endmodule

// File: hw/rtl/nla_arrange.sv
// Stage 4: pivot swap and suffix reversal into the output register.
`include "next_lexicographic_arrangement_assert.svh"
module nla_arrange
    import nla_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  s3_t   in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t word_out,
    output logic  wrapped
);

    logic  valid_reg;
    word_t word_reg;
    word_t word_next;
    logic  wrap_reg;
    len_t  n_reg;
    idx_t  lo;
    idx_t  src;
    logic  [LEN_W:0] mirror;
    logic  sorted;

    always_comb
    begin
        // reversal starts after the pivot, or at zero on wrap-around
        lo = in_data.wrap ? '0 : in_data.p + 1'b1;
        for (int k = 0; k < MAX_LEN; k++)
        begin
            mirror = (LEN_W+1)'(lo) + (LEN_W+1)'(in_data.n) - (LEN_W+1)'(k) - (LEN_W+1)'(1);
            if ((IDX_W'(k) >= lo) && (LEN_W'(k) < in_data.n))
                src = mirror[IDX_W-1:0];
            else
                src = IDX_W'(k);
            if (!in_data.wrap && (src == in_data.p))
                word_next[k] = in_data.word[in_data.j];
            else if (!in_data.wrap && (src == in_data.j))
                word_next[k] = in_data.word[in_data.p];
            else
                word_next[k] = in_data.word[src];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
            wrap_reg <= in_data.wrap;
            n_reg    <= in_data.n;
        end
    end

    assign out_valid = valid_reg;
    assign word_out  = word_reg;
    assign wrapped   = wrap_reg;

    always_comb
    begin
        sorted = 1'b1;
        for (int k = 0; k < MAX_LEN - 1; k++)
        begin
            if ((LEN_W'(k + 1) < n_reg) && (word_reg[k] > word_reg[k + 1]))
                sorted = 1'b0;
        end
    end

    // a wrap-around result must be the first arrangement
    `NLA_ASSERT_IMPLY(a_wrap_sorted, valid_reg && wrap_reg, sorted)

endmodule

// File: hw/rtl/next_lexicographic_arrangement.sv
// Four register stages lie between request acceptance and result valid.
// Throughput: one request per cycle unless the output stalls; stages are detect, pivot, successor, arrange.
// Each stage stalls only when full and blocked, so bubbles close up under backpressure.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits; data is not reset.
// Top level: next lexicographic arrangement of up to eight symbols.
module next_lexicographic_arrangement
    import nla_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [LEN_IN_W-1:0] sym_count,
    input  sym_t                in_sym_0,
    input  sym_t                in_sym_1,
    input  sym_t                in_sym_2,
    input  sym_t                in_sym_3,
    input  sym_t                in_sym_4,
    input  sym_t                in_sym_5,
    input  sym_t                in_sym_6,
    input  sym_t                in_sym_7,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output sym_t                out_sym_0,
    output sym_t                out_sym_1,
    output sym_t                out_sym_2,
    output sym_t                out_sym_3,
    output sym_t                out_sym_4,
    output sym_t                out_sym_5,
    output sym_t                out_sym_6,
    output sym_t                out_sym_7,
    output logic                wrapped
);

    // Position 0 is the most significant symbol in the ordering.
    word_t word_in;
    word_t word_out;

    // inter-stage handshakes
    logic s1_valid;
    logic s1_ready;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_ready;
    s2_t  s2_data;
    logic s3_valid;
    logic s3_ready;
    s3_t  s3_data;

    assign word_in[0] = in_sym_0;
    assign word_in[1] = in_sym_1;
    assign word_in[2] = in_sym_2;
    assign word_in[3] = in_sym_3;
    assign word_in[4] = in_sym_4;
    assign word_in[5] = in_sym_5;
    assign word_in[6] = in_sym_6;
    assign word_in[7] = in_sym_7;

    // Stage 1: clamp the length and flag every ascent inside it.
    nla_detect u_detect (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sym_count (sym_count),
        .word_in   (word_in),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Stage 2: rightmost ascent is the pivot; none means the last arrangement.
    nla_pivot u_pivot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Stage 3: rightmost symbol beyond the pivot that beats it.
    nla_succ u_succ (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    // Stage 4: swap and reverse; on wrap the whole valid part is reversed.
    // Its register is the output register, so the result is held while stalled.
    nla_arrange u_arrange (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid),
        .in_ready  (s3_ready),
        .in_data   (s3_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .word_out  (word_out),
        .wrapped   (wrapped)
    );

    assign out_sym_0 = word_out[0];
    assign out_sym_1 = word_out[1];
    assign out_sym_2 = word_out[2];
    assign out_sym_3 = word_out[3];
    assign out_sym_4 = word_out[4];
    assign out_sym_5 = word_out[5];
    assign out_sym_6 = word_out[6];
    assign out_sym_7 = word_out[7];

endmodule

// File: bench/tb_next_lexicographic_arrangement.sv
// Self-checking testbench for the next lexicographic arrangement block.
module tb_next_lexicographic_arrangement
    import nla_pkg::*;
();

    // One request as driven on the input channel.
    typedef struct {
        logic [LEN_IN_W-1:0] len;
        word_t               syms;
    } request_t;

    // One result as seen on the output channel.
    typedef struct {
        word_t syms;
        logic  wrap;
    } arrangement_t;

    // Directed row: typed rows carry a hand-written expectation, the rest
    // fall back on the predictor.
    typedef struct {
        request_t     rq;
        bit           typed;
        arrangement_t exp;
    } table_row_t;

    localparam int RANDOM_REQUESTS = 700;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [LEN_IN_W-1:0] sym_count;
    sym_t                in_sym_0, in_sym_1, in_sym_2, in_sym_3;
    sym_t                in_sym_4, in_sym_5, in_sym_6, in_sym_7;
    logic                out_valid;
    logic                out_ready;
    sym_t                out_sym_0, out_sym_1, out_sym_2, out_sym_3;
    sym_t                out_sym_4, out_sym_5, out_sym_6, out_sym_7;
    logic                wrapped;

    arrangement_t pending_arrangements[$];
    table_row_t   stimulus_table[$];
    int           mismatch_count;
    // Set for stretches in which neither side idles at all.
    bit           no_idle;

    next_lexicographic_arrangement dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sym_count   (sym_count),
        .in_sym_0    (in_sym_0),
        .in_sym_1    (in_sym_1),
        .in_sym_2    (in_sym_2),
        .in_sym_3    (in_sym_3),
        .in_sym_4    (in_sym_4),
        .in_sym_5    (in_sym_5),
        .in_sym_6    (in_sym_6),
        .in_sym_7    (in_sym_7),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sym_0   (out_sym_0),
        .out_sym_1   (out_sym_1),
        .out_sym_2   (out_sym_2),
        .out_sym_3   (out_sym_3),
        .out_sym_4   (out_sym_4),
        .out_sym_5   (out_sym_5),
        .out_sym_6   (out_sym_6),
        .out_sym_7   (out_sym_7),
        .wrapped     (wrapped)
    );

    // 12-unit clock period.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predictor: rightmost ascent is the pivot, swap it with the rightmost
    // larger symbol, then reverse the tail. No ascent (or a length of one or
    // zero) means the word was the last arrangement: reverse the valid part
    // back to ascending order and flag the wrap. Lanes at or past the length
    // are copied through; lengths above eight saturate.
    function automatic arrangement_t next_arrangement(request_t rq);
        arrangement_t res;
        word_t        w;
        sym_t         t;
        int           n;
        int           p;
        int           j;
        int           lo;
        int           hi;
        w   = rq.syms;
        n   = (rq.len > MAX_LEN) ? MAX_LEN : int'(rq.len);
        res.wrap = 1'b0;
        if (n <= 1)
        begin
            res.wrap = 1'b1;
        end
        else
        begin
            for (p = n - 2; p >= 0; p--)
                if (w[p] < w[p+1])
                    break;
            if (p < 0)
            begin
                lo = 0;
                res.wrap = 1'b1;
            end
            else
            begin
                j = n - 1;
                while (w[j] <= w[p])
                    j--;
                t    = w[p];
                w[p] = w[j];
                w[j] = t;
                lo   = p + 1;
            end
            hi = n - 1;
            while (lo < hi)
            begin
                t     = w[lo];
                w[lo] = w[hi];
                w[hi] = t;
                lo++;
                hi--;
            end
        end
        res.syms = w;
        return res;
    endfunction

    function automatic word_t mk(sym_t s0, sym_t s1, sym_t s2, sym_t s3,
                                 sym_t s4, sym_t s5, sym_t s6, sym_t s7);
        word_t w;
        w[0] = s0; w[1] = s1; w[2] = s2; w[3] = s3;
        w[4] = s4; w[5] = s5; w[6] = s6; w[7] = s7;
        return w;
    endfunction

    task automatic add_row(logic [LEN_IN_W-1:0] len, word_t syms, bit typed,
                           word_t exp_syms, logic exp_wrap);
        table_row_t row;
        row.rq.len    = len;
        row.rq.syms   = syms;
        row.typed     = typed;
        row.exp.syms  = exp_syms;
        row.exp.wrap  = exp_wrap;
        stimulus_table.push_back(row);
    endtask

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Small alphabets give plenty of repeated symbols; the rest cover every
    // bit and the extremes of the 16-bit range.
    function automatic sym_t rand_sym(int flavour);
        sym_t extremes[6];
        extremes = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF};
        case (flavour)
            0:       return sym_t'($urandom_range(0, 3));
            1:       return sym_t'($urandom);
            default: return extremes[$urandom_range(0, 5)];
        endcase
    endfunction

    function automatic logic [LEN_IN_W-1:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return LEN_IN_W'($urandom_range(1, MAX_LEN));
        else if (r < 90)
            return '0;
        else
            return LEN_IN_W'($urandom_range(MAX_LEN + 1, 15));
    endfunction

    function automatic request_t rand_request(int flavour);
        request_t rq;
        rq.len = rand_len();
        for (int k = 0; k < MAX_LEN; k++)
            rq.syms[k] = rand_sym(flavour);
        return rq;
    endfunction

    // Result side: check each accepted result against the oldest
    // expectation, and stall out_ready at random.
    initial
    begin
        arrangement_t got;
        arrangement_t exp;
        int           hold;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                got.syms = {out_sym_7, out_sym_6, out_sym_5, out_sym_4,
                            out_sym_3, out_sym_2, out_sym_1, out_sym_0};
                got.wrap = wrapped;
                if (pending_arrangements.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result at %0t: wrapped=%b", $realtime, got.wrap);
                end
                else
                begin
                    exp = pending_arrangements.pop_front();
                    if (got.syms !== exp.syms || got.wrap !== exp.wrap)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            for (int k = 0; k < MAX_LEN; k++)
                                if (got.syms[k] !== exp.syms[k])
                                    $display("mismatch at %0t: out_sym_%0d exp %h got %h",
                                             $realtime, k, exp.syms[k], got.syms[k]);
                            if (got.wrap !== exp.wrap)
                                $display("mismatch at %0t: wrapped exp %b got %b",
                                         $realtime, exp.wrap, got.wrap);
                        end
                    end
                end
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // Request side: directed table, then random requests, then drain.
    initial
    begin
        request_t     rq;
        request_t     chain_rq;
        arrangement_t exp;
        table_row_t   row;
        int           gap;
        int           chain_left;
        int           flavour;
        int           n;

        mismatch_count = 0;
        no_idle        = 1'b0;
        chain_left     = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        sym_count      <= '0;
        in_sym_0 <= '0; in_sym_1 <= '0; in_sym_2 <= '0; in_sym_3 <= '0;
        in_sym_4 <= '0; in_sym_5 <= '0; in_sym_6 <= '0; in_sym_7 <= '0;

        // Directed rows: single symbol, empty word, saturated lengths, the
        // last arrangement, all-equal words, repeats and lane pass-through.
        add_row(1, mk(16'h1234, 16'h0001, 16'hFFFF, 16'h0000,
                      16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF), 1,
                   mk(16'h1234, 16'h0001, 16'hFFFF, 16'h0000,
                      16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF), 1'b1);
        add_row(0, mk(16'h0000, 16'h0001, 16'h0002, 16'h0003,
                      16'h0004, 16'h0005, 16'h0006, 16'h0007), 1,
                   mk(16'h0000, 16'h0001, 16'h0002, 16'h0003,
                      16'h0004, 16'h0005, 16'h0006, 16'h0007), 1'b1);
        add_row(8, mk(16'h0007, 16'h0006, 16'h0005, 16'h0004,
                      16'h0003, 16'h0002, 16'h0001, 16'h0000), 1,
                   mk(16'h0000, 16'h0001, 16'h0002, 16'h0003,
                      16'h0004, 16'h0005, 16'h0006, 16'h0007), 1'b1);
        add_row(8, mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
                   mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
        add_row(8, '0, 1, '0, 1'b1);
        add_row(2, mk(16'h0000, 16'hFFFF, 16'h1111, 16'h2222,
                      16'h3333, 16'h4444, 16'h5555, 16'h6666), 1,
                   mk(16'hFFFF, 16'h0000, 16'h1111, 16'h2222,
                      16'h3333, 16'h4444, 16'h5555, 16'h6666), 1'b0);
        add_row(2, mk(16'hFFFF, 16'h0000, 16'h1111, 16'h2222,
                      16'h3333, 16'h4444, 16'h5555, 16'h6666), 1,
                   mk(16'h0000, 16'hFFFF, 16'h1111, 16'h2222,
                      16'h3333, 16'h4444, 16'h5555, 16'h6666), 1'b1);
        add_row(5, mk(16'h0005, 16'h0005, 16'h0003, 16'h0003,
                      16'h0000, 16'hDEAD, 16'hBEEF, 16'hCAFE), 1,
                   mk(16'h0000, 16'h0003, 16'h0003, 16'h0005,
                      16'h0005, 16'hDEAD, 16'hBEEF, 16'hCAFE), 1'b1);
        add_row(9, mk(16'h0007, 16'h0006, 16'h0005, 16'h0004,
                      16'h0003, 16'h0002, 16'h0001, 16'h0000), 1,
                   mk(16'h0000, 16'h0001, 16'h0002, 16'h0003,
                      16'h0004, 16'h0005, 16'h0006, 16'h0007), 1'b1);
        add_row(15, mk(16'h0000, 16'h0001, 16'h0002, 16'h0003,
                       16'h0004, 16'h0005, 16'h0006, 16'h0007), 0, '0, 1'b0);
        add_row(8, mk(16'h0000, 16'h0001, 16'h0002, 16'h0003,
                      16'h0004, 16'h0005, 16'h0006, 16'h0007), 0, '0, 1'b0);
        add_row(12, mk(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                       16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000), 0, '0, 1'b0);
        add_row(4, mk(16'h0001, 16'h0002, 16'h0002, 16'h0001,
                      16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555), 0, '0, 1'b0);
        add_row(3, mk(16'h0001, 16'h0003, 16'h0002, 16'hAAAA,
                      16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA), 0, '0, 1'b0);
        add_row(6, mk(16'h0002, 16'h0001, 16'h0003, 16'h0003,
                      16'h0003, 16'h0001, 16'hFFFF, 16'hFFFF), 0, '0, 1'b0);
        add_row(7, mk(16'h8000, 16'h7FFF, 16'hFFFE, 16'h0001,
                      16'hFFFF, 16'h0000, 16'h8000, 16'h1234), 0, '0, 1'b0);
        add_row(10, mk(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                       16'h0001, 16'h0001, 16'h0002, 16'h0001), 0, '0, 1'b0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < stimulus_table.size() + RANDOM_REQUESTS; i++)
        begin
            if (i < stimulus_table.size())
            begin
                row = stimulus_table[i];
                rq  = row.rq;
                if (row.typed)
                    exp = row.exp;
                else
                    exp = next_arrangement(rq);
            end
            else
            begin
                if (i % 100 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if (chain_left > 0)
                begin
                    // Walk the arrangement stream: feed the last result back,
                    // now and then breaking the sequence with one stray symbol.
                    exp           = next_arrangement(chain_rq);
                    chain_rq.syms = exp.syms;
                    if ($urandom_range(0, 19) == 0)
                        chain_rq.syms[$urandom_range(0, MAX_LEN - 1)] = rand_sym(1);
                    rq = chain_rq;
                    chain_left--;
                end
                else if ($urandom_range(0, 99) < 70)
                begin
                    // Start a chain, mostly short words so wraps come often.
                    flavour = ($urandom_range(0, 3) == 0) ? 1 : 0;
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, MAX_LEN)
                                                    : $urandom_range(2, 5);
                    chain_rq = rand_request(flavour);
                    chain_rq.len = LEN_IN_W'(n);
                    for (int k = 0; k < n; k++)
                        chain_rq.syms[k] = rand_sym(flavour);
                    rq = chain_rq;
                    chain_left = $urandom_range(5, 30);
                end
                else
                begin
                    rq = rand_request($urandom_range(0, 2));
                end
                exp = next_arrangement(rq);
            end

            gap = pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid    <= 1'b1;
            sym_count   <= rq.len;
            in_sym_0 <= rq.syms[0]; in_sym_1 <= rq.syms[1];
            in_sym_2 <= rq.syms[2]; in_sym_3 <= rq.syms[3];
            in_sym_4 <= rq.syms[4]; in_sym_5 <= rq.syms[5];
            in_sym_6 <= rq.syms[6]; in_sym_7 <= rq.syms[7];
            do
                @(posedge clk);
            while (in_ready !== 1'b1);
            pending_arrangements.push_back(exp);
        end
        in_valid <= 1'b0;

        // Drain, then wait on for any stray result.
        while (pending_arrangements.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (mismatch_count == 0 && pending_arrangements.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
